// ===== design/rmq_pkg.sv =====
// Shared widths, types and constants for the rotation matrix to quaternion core.
package rmq_pkg;

  localparam int ELEM_W    = 16;
  localparam int ELEMS     = 9;
  localparam int IN_W      = ELEM_W * ELEMS;
  localparam int LANES     = 4;
  localparam int OUT_W     = ELEM_W * LANES;
  localparam int CALC_W    = 19;
  localparam int MAG_W     = 17;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = 36;
  localparam int ROOT_W    = 32;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int NUM_SHIFT = 29;
  localparam int NUM_W     = MAG_W + NUM_SHIFT + 1;
  localparam int QUO_W     = 16;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic signed [CALC_W-1:0] ONE_Q14 = CALC_W'(16384);
  localparam logic [ELEM_W-1:0]        Q_MAX   = 16'h7FFF;
  localparam logic [ELEM_W-1:0]        Q_MIN   = 16'h8000;

  typedef struct packed {
    logic                        zero;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } vec_t;

endpackage

// ===== design/rmq_front.sv =====
// Front end: accepts a matrix, picks the branch and forms the scaled vector.
module rmq_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [rmq_pkg::IN_W-1:0] s_tdata,
  output logic                     push,
  input  logic                     full,
  output rmq_pkg::vec_t            vec
);
  import rmq_pkg::*;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  logic signed [CALC_W-1:0] a [ELEMS];
  logic signed [CALC_W-1:0] tr;
  logic signed [CALC_W-1:0] d;
  logic signed [CALC_W-1:0] v [LANES];
  logic [1:0]               br;
  logic                     fr_valid;
  vec_t                     vec_in;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [CALC_W-1:0] x);
    logic [CALC_W-1:0] t;
    t = x[CALC_W-1] ? CALC_W'(-x) : CALC_W'(x);
    return t[MAG_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < ELEMS; i++) begin
      a[i] = {{(CALC_W-ELEM_W){s_tdata[ELEM_W*i+ELEM_W-1]}}, s_tdata[ELEM_W*i +: ELEM_W]};
    end
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      br = BR_TRACE;
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      br = BR_X;
    end else if (a[4] > a[8]) begin
      br = BR_Y;
    end else begin
      br = BR_Z;
    end
    unique case (br)
      BR_TRACE: begin
        d    = ONE_Q14 + tr;
        v[0] = d;
        v[1] = a[7] - a[5];
        v[2] = a[2] - a[6];
        v[3] = a[3] - a[1];
      end
      BR_X: begin
        d    = ONE_Q14 + a[0] - a[4] - a[8];
        v[0] = a[7] - a[5];
        v[1] = d;
        v[2] = a[1] + a[3];
        v[3] = a[2] + a[6];
      end
      BR_Y: begin
        d    = ONE_Q14 + a[4] - a[0] - a[8];
        v[0] = a[2] - a[6];
        v[1] = a[1] + a[3];
        v[2] = d;
        v[3] = a[5] + a[7];
      end
      default: begin
        d    = ONE_Q14 + a[8] - a[0] - a[4];
        v[0] = a[3] - a[1];
        v[1] = a[2] + a[6];
        v[2] = a[5] + a[7];
        v[3] = d;
      end
    endcase
    vec_in.zero = (d <= 0);
    for (int l = 0; l < LANES; l++) begin
      vec_in.neg[l] = v[l][CALC_W-1];
      vec_in.mag[l] = mag_of(v[l]);
    end
  end

  assign s_tready = !fr_valid || !full;
  assign push     = fr_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      vec <= vec_in;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    fr_valid && !push |=> fr_valid && $stable(vec))
    else $error("front request lost while queue full");

endmodule

// ===== design/rmq_queue.sv =====
// Short request queue between front end and arithmetic back end.
module rmq_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rmq_pkg::vec_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rmq_pkg::vec_t rdata
);
  import rmq_pkg::*;

  vec_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue overrun or underrun");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    wr_ptr == QPTR_W'(rd_ptr + count[QPTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule

// ===== design/rmq_back.sv =====
// Back end: sum of squares, pipelined square root, four pipelined dividers.
module rmq_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      empty,
  input  rmq_pkg::vec_t             vec,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rmq_pkg::OUT_W-1:0] m_tdata
);
  import rmq_pkg::*;

  logic en;

  logic                       sq_valid;
  vec_t                       sq_vec;
  logic [LANES-1:0][SQ_W-1:0] sq_sq;

  logic              rt_valid [ROOT_W+1];
  vec_t              rt_vec   [ROOT_W+1];
  logic [SUM_W-1:0]  rt_s     [ROOT_W+1];
  logic [REM_W-1:0]  rt_rem   [ROOT_W+1];
  logic [ROOT_W-1:0] rt_root  [ROOT_W+1];

  logic                        dv_valid [QUO_W+1];
  logic                        dv_zero  [QUO_W+1];
  logic [LANES-1:0]            dv_neg   [QUO_W+1];
  logic [DEN_W-1:0]            dv_den   [QUO_W+1];
  logic [LANES-1:0][NUM_W-1:0] dv_rem   [QUO_W+1];
  logic [LANES-1:0][QUO_W-1:0] dv_quo   [QUO_W+1];

  logic [OUT_W-1:0] res;

  assign en  = !m_tvalid || m_tready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (en) begin
      sq_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_vec <= vec;
      for (int l = 0; l < LANES; l++) begin
        sq_sq[l] <= SQ_W'(vec.mag[l]) * SQ_W'(vec.mag[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_valid[0] <= 1'b0;
    end else if (en) begin
      rt_valid[0] <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_vec[0]  <= sq_vec;
      rt_s[0]    <= SUM_W'(sq_sq[0]) + SUM_W'(sq_sq[1]) + SUM_W'(sq_sq[2])
                    + SUM_W'(sq_sq[3]);
      rt_rem[0]  <= '0;
      rt_root[0] <= '0;
    end
  end

  // radicand is the sum shifted up by 28 bits; two radicand bits per stage
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic [1:0]       pair;
    logic [REM_W+1:0] remw;
    logic [REM_W+1:0] trial;
    logic             ge;

    if (SUM_W - 1 - 2 * i >= 1) begin : g_bits
      assign pair = rt_s[i][SUM_W-1-2*i -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign remw  = {rt_rem[i], pair};
    assign trial = (REM_W+2)'({rt_root[i], 2'b01});
    assign ge    = (remw >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_valid[i+1] <= 1'b0;
      end else if (en) begin
        rt_valid[i+1] <= rt_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_vec[i+1]  <= rt_vec[i];
        rt_s[i+1]    <= rt_s[i];
        rt_rem[i+1]  <= ge ? REM_W'(remw - trial) : remw[REM_W-1:0];
        rt_root[i+1] <= {rt_root[i][ROOT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= rt_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_zero[0] <= rt_vec[ROOT_W].zero || (rt_root[ROOT_W] == '0);
      dv_neg[0]  <= rt_vec[ROOT_W].neg;
      dv_den[0]  <= {rt_root[ROOT_W], 1'b0};
      dv_quo[0]  <= '0;
      for (int l = 0; l < LANES; l++) begin
        dv_rem[0][l] <= NUM_W'({rt_vec[ROOT_W].mag[l], {NUM_SHIFT{1'b0}}})
                        + NUM_W'(rt_root[ROOT_W]);
      end
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int B = QUO_W - 1 - j;
    logic [NUM_W:0]              dk;
    logic [LANES-1:0]            ge;
    logic [LANES-1:0][NUM_W-1:0] rem_n;
    logic [LANES-1:0][QUO_W-1:0] quo_n;

    assign dk = (NUM_W+1)'(dv_den[j]) << B;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        ge[l]    = ({1'b0, dv_rem[j][l]} >= dk);
        rem_n[l] = ge[l] ? NUM_W'({1'b0, dv_rem[j][l]} - dk) : dv_rem[j][l];
        quo_n[l] = dv_quo[j][l];
        quo_n[l][B] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (en) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_zero[j+1] <= dv_zero[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_den[j+1]  <= dv_den[j];
        dv_rem[j+1]  <= rem_n;
        dv_quo[j+1]  <= quo_n;
      end
    end
  end

  always_comb begin
    logic [QUO_W-1:0] sat;
    for (int l = 0; l < LANES; l++) begin
      sat = dv_quo[QUO_W][l][QUO_W-1] ? Q_MAX : dv_quo[QUO_W][l];
      if (dv_zero[QUO_W]) begin
        res[ELEM_W*l +: ELEM_W] = '0;
      end else if (dv_neg[QUO_W][l]) begin
        res[ELEM_W*l +: ELEM_W] = ELEM_W'(-sat);
      end else begin
        res[ELEM_W*l +: ELEM_W] = sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res;
    end
  end

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:0] != Q_MIN && m_tdata[31:16] != Q_MIN
                 && m_tdata[47:32] != Q_MIN && m_tdata[63:48] != Q_MIN)
    else $error("quaternion component outside saturated range");

endmodule

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// Top level of the rotation matrix to quaternion core.
// Converts a 3x3 Q1.14 rotation matrix to a normalised Q1.14 quaternion using
// Shepperd's branch choice, one matrix per clock cycle sustained while the
// receiver keeps m_tready high. A request passes a front register, the
// request queue, a register for the squares and one for their sum, a 32-stage
// square root, a set-up register and a 16-stage divider for each component,
// and the output register. Throughput is set by the fully pipelined root and
// dividers; a four-entry queue decouples the front end from the arithmetic.
// A branch with a non-positive diagonal term returns the zero quaternion.
module rotation_matrix_to_quaternion_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // e00, e01, e02, e10, e11, e12, e20, e21, e22
  input  logic [rmq_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // qw, qx, qy, qz
  output logic [rmq_pkg::OUT_W-1:0] m_tdata
);
  import rmq_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  vec_t front_vec;
  vec_t queue_vec;

  rmq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .push     (push),
    .full     (full),
    .vec      (front_vec)
  );

  rmq_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_vec),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .rdata (queue_vec)
  );

  rmq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .vec      (queue_vec),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the rotation matrix to quaternion core, checked against a fixed-point predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmq_pkg::*;

  typedef logic signed [15:0] elem_t;
  typedef struct {
    logic [15:0] qw, qx, qy, qz;
  } quat_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  logic [IN_W-1:0] pending_matrices[$];
  quat_t expected_quats[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  rotation_matrix_to_quaternion_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rem, root, b;
    rem = x;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] scale_lane(longint v, longint unsigned len);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q = (mag * (64'd1 << 29) + len) / (2 * len);
    if (q > 32767) q = 32767;
    return (v < 0) ? 16'(-longint'(q)) : 16'(q);
  endfunction

  function automatic quat_t matrix_to_quat(logic [IN_W-1:0] m);
    longint a[9];
    longint v[4];
    longint tr, d;
    longint unsigned sum, len;
    quat_t r;
    for (int i = 0; i < 9; i++) a[i] = longint'(elem_t'(m[16*i +: 16]));
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      d = 16384 + tr;
      v = '{d, a[7] - a[5], a[2] - a[6], a[3] - a[1]};
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      d = 16384 + a[0] - a[4] - a[8];
      v = '{a[7] - a[5], d, a[1] + a[3], a[2] + a[6]};
    end else if (a[4] > a[8]) begin
      d = 16384 + a[4] - a[0] - a[8];
      v = '{a[2] - a[6], a[1] + a[3], d, a[5] + a[7]};
    end else begin
      d = 16384 + a[8] - a[0] - a[4];
      v = '{a[3] - a[1], a[2] + a[6], a[5] + a[7], d};
    end
    r = '{16'h0, 16'h0, 16'h0, 16'h0};
    if (d <= 0) return r;
    sum = 0;
    for (int i = 0; i < 4; i++) sum += v[i] * v[i];
    len = int_sqrt(sum << 28);
    if (len == 0) return r;
    r.qw = scale_lane(v[0], len);
    r.qx = scale_lane(v[1], len);
    r.qy = scale_lane(v[2], len);
    r.qz = scale_lane(v[3], len);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_matrix(int e[9]);
    logic [IN_W-1:0] m;
    for (int i = 0; i < 9; i++) m[16*i +: 16] = 16'(e[i]);
    return m;
  endfunction

  // near-rotation: scaled signed permutation plus small noise
  function automatic logic [IN_W-1:0] rand_rotation();
    int e[9];
    int perm[3];
    int p;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      int j;
      j = $urandom_range(i, 0);
      p = perm[i]; perm[i] = perm[j]; perm[j] = p;
    end
    for (int i = 0; i < 9; i++) e[i] = $urandom_range(4000, 0) - 2000;
    for (int r = 0; r < 3; r++)
      e[3*r + perm[r]] += ($urandom_range(1, 0) ? 1 : -1) * $urandom_range(16384, 8000);
    return pack_matrix(e);
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    mismatch_count++;
  endtask

  // driver: bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      logic fire;
      fire = s_tvalid && s_tready;
      if (fire) expected_quats.push_back(matrix_to_quat(s_tdata));
      if (fire || !s_tvalid) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_matrices.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_matrices.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(40, 1);
            gap_left = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(6, 1);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        quat_t want;
        if (expected_quats.size() == 0) begin
          $display("result with no request outstanding: %h", m_tdata);
          mismatch_count++;
        end else begin
          want = expected_quats.pop_front();
          if (m_tdata[15:0] !== want.qw) report_mismatch("qw", m_tdata[15:0], want.qw);
          if (m_tdata[31:16] !== want.qx) report_mismatch("qx", m_tdata[31:16], want.qx);
          if (m_tdata[47:32] !== want.qy) report_mismatch("qy", m_tdata[47:32], want.qy);
          if (m_tdata[63:48] !== want.qz) report_mismatch("qz", m_tdata[63:48], want.qz);
        end
      end
      stall_phase <= (stall_phase + 1) % 512;
      if (stall_phase < 128) m_tready <= 1'b1;
      else if (stall_phase < 256) m_tready <= ($urandom_range(3, 0) != 0);
      else if (stall_phase < 300) m_tready <= ($urandom_range(3, 0) == 0);
      else m_tready <= ($urandom_range(1, 0) == 1);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int e[9];
    e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    pending_matrices.push_back(pack_matrix(e));
    e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
    pending_matrices.push_back(pack_matrix(e));
    e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
    pending_matrices.push_back(pack_matrix(e));
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
    pending_matrices.push_back(pack_matrix(e));
    // rotation of 90 degrees about z
    e = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};
    pending_matrices.push_back(pack_matrix(e));
    // all elements equal: the extremes, minus one and zero
    pending_matrices.push_back({9{16'h7FFF}});
    pending_matrices.push_back({9{16'h8000}});
    pending_matrices.push_back({9{16'hFFFF}});
    pending_matrices.push_back('0);
    // trace zero, ties on the diagonal
    e = '{0, 5, 7, -3, 0, 9, 1, 2, 0};
    pending_matrices.push_back(pack_matrix(e));
    e = '{-5000, 100, 200, 300, -5000, 400, 500, 600, 10000};
    pending_matrices.push_back(pack_matrix(e));
    // extreme elements; the branch term stays positive
    e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    pending_matrices.push_back(pack_matrix(e));
    e = '{32767, 0, 0, 0, 32767, 0, 0, 0, -32768};
    pending_matrices.push_back(pack_matrix(e));
    // off-diagonals at the extremes with positive and negative trace, then trace zero
    e = '{1, -32768, 32767, 32767, 1, -32768, -32768, 32767, 1};
    pending_matrices.push_back(pack_matrix(e));
    e = '{-16384, 32767, 32767, 32767, -16384, 32767, 32767, 32767, -16384};
    pending_matrices.push_back(pack_matrix(e));
    e = '{0, 0, 0, 0, -1, 0, 0, 0, 1};
    pending_matrices.push_back(pack_matrix(e));
    repeat (1350) begin
      if ($urandom_range(3, 0) != 0) begin
        pending_matrices.push_back(rand_rotation());
      end else begin
        logic [IN_W-1:0] m;
        for (int i = 0; i < IN_W; i += 16) m[i +: 16] = 16'($urandom);
        pending_matrices.push_back(m);
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_matrices.size() == 0);
    @(posedge clk);
    while (s_tvalid || expected_quats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
